// File: design/thick_line_quad_vertices_core_defines.svh
// assertion macros shared by the thick-line quad expansion design
`ifndef THICK_LINE_QUAD_VERTICES_CORE_DEFINES_SVH
`define THICK_LINE_QUAD_VERTICES_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TLQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlq check failed");
`define TLQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlq check failed");
`else
`define TLQ_ASSERT_IMP(lbl, ante, cons)
`define TLQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: design/tlq_pkg.sv
// shared constants of the thick-line quad expansion design
`timescale 1ns / 1ps
package tlq_pkg;
  localparam int COORD_BITS_DEF = 20;
  localparam int WIDTH_BITS     = 12;
  localparam int MAG_BITS       = 12;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 12'd16;
  localparam int ADDR_BITS      = 3;
  localparam int DATA_BITS      = 32;
  localparam logic REG_LINE_WIDTH = 1'b0;
endpackage

// File: design/tlq_prep.sv
// front stages: differences, magnitudes, squares and squared numerators
`timescale 1ns / 1ps
module tlq_prep #(
  parameter int COORD_BITS = tlq_pkg::COORD_BITS_DEF,
  localparam int AB = COORD_BITS + 1,
  localparam int NB = AB + tlq_pkg::WIDTH_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              i_valid,
  output logic                              i_rdy,
  input  logic [COORD_BITS-1:0]             i_sx,
  input  logic [COORD_BITS-1:0]             i_sy,
  input  logic [COORD_BITS-1:0]             i_ex,
  input  logic [COORD_BITS-1:0]             i_ey,
  input  logic [tlq_pkg::WIDTH_BITS-1:0]    i_width,
  output logic                              o_valid,
  input  logic                              o_rdy,
  output logic [4*COORD_BITS-1:0]           o_pt,
  output logic                              o_dx_pos,
  output logic                              o_dy_neg,
  output logic [2*AB:0]                     o_s,
  output logic [2*NB-1:0]                   o_nx2,
  output logic [2*NB-1:0]                   o_ny2
);
  import tlq_pkg::*;

  logic v0_r, v1_r, v2_r;
  logic adv0, adv1, adv2;
  logic [AB-1:0] dx, dy, ax_nxt, ay_nxt;
  logic [AB-1:0] ax_r, ay_r;
  logic [4*COORD_BITS-1:0] pt0_r, pt1_r, pt2_r;
  logic dxp0_r, dyn0_r, dxp1_r, dyn1_r, dxp2_r, dyn2_r;
  logic [2*AB-1:0] sqx_r, sqy_r;
  logic [NB-1:0] nx_r, ny_r;
  logic [2*AB:0] s_r;
  logic [2*NB-1:0] nx2_r, ny2_r;

  assign adv2  = !v2_r || o_rdy;
  assign adv1  = !v1_r || adv2;
  assign adv0  = !v0_r || adv1;
  assign i_rdy = adv0;

  // differences one bit wider than a coordinate never wrap
  assign dx = {i_ex[COORD_BITS-1], i_ex} - {i_sx[COORD_BITS-1], i_sx};
  assign dy = {i_ey[COORD_BITS-1], i_ey} - {i_sy[COORD_BITS-1], i_sy};
  assign ax_nxt = dx[AB-1] ? (~dx + 1'b1) : dx;
  assign ay_nxt = dy[AB-1] ? (~dy + 1'b1) : dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv0) v0_r <= i_valid;
      if (adv1) v1_r <= v0_r;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0 && i_valid) begin
      pt0_r  <= {i_sx, i_sy, i_ex, i_ey};
      ax_r   <= ax_nxt;
      ay_r   <= ay_nxt;
      dxp0_r <= !dx[AB-1] && (dx != '0);
      dyn0_r <= dy[AB-1];
    end
    if (adv1 && v0_r) begin
      pt1_r  <= pt0_r;
      dxp1_r <= dxp0_r;
      dyn1_r <= dyn0_r;
      sqx_r  <= ax_r * ax_r;
      sqy_r  <= ay_r * ay_r;
      nx_r   <= ay_r * i_width;
      ny_r   <= ax_r * i_width;
    end
    if (adv2 && v1_r) begin
      pt2_r  <= pt1_r;
      dxp2_r <= dxp1_r;
      dyn2_r <= dyn1_r;
      s_r    <= {1'b0, sqx_r} + {1'b0, sqy_r};
      nx2_r  <= nx_r * nx_r;
      ny2_r  <= ny_r * ny_r;
    end
  end

  assign o_valid  = v2_r;
  assign o_pt     = pt2_r;
  assign o_dx_pos = dxp2_r;
  assign o_dy_neg = dyn2_r;
  assign o_s      = s_r;
  assign o_nx2    = nx2_r;
  assign o_ny2    = ny2_r;
endmodule

// File: design/tlq_cell.sv
// one cell of the magnitude search: settles one result bit for x and y
`timescale 1ns / 1ps
module tlq_cell #(
  parameter int COORD_BITS = tlq_pkg::COORD_BITS_DEF,
  parameter int BIT = 0,
  localparam int AB = COORD_BITS + 1,
  localparam int NB = AB + tlq_pkg::WIDTH_BITS,
  localparam int TW = 2*AB + 2*tlq_pkg::MAG_BITS + 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         i_valid,
  output logic                         i_rdy,
  input  logic [4*COORD_BITS-1:0]      i_pt,
  input  logic                         i_dx_pos,
  input  logic                         i_dy_neg,
  input  logic [2*AB:0]                i_s,
  input  logic [2*NB-1:0]              i_nx2,
  input  logic [2*NB-1:0]              i_ny2,
  input  logic [tlq_pkg::MAG_BITS-1:0] i_cx,
  input  logic [tlq_pkg::MAG_BITS-1:0] i_cy,
  input  logic [TW-1:0]                i_xa,
  input  logic [TW-1:0]                i_xb,
  input  logic [TW-1:0]                i_ya,
  input  logic [TW-1:0]                i_yb,
  output logic                         o_valid,
  input  logic                         o_rdy,
  output logic [4*COORD_BITS-1:0]      o_pt,
  output logic                         o_dx_pos,
  output logic                         o_dy_neg,
  output logic [2*AB:0]                o_s,
  output logic [2*NB-1:0]              o_nx2,
  output logic [2*NB-1:0]              o_ny2,
  output logic [tlq_pkg::MAG_BITS-1:0] o_cx,
  output logic [tlq_pkg::MAG_BITS-1:0] o_cy,
  output logic [TW-1:0]                o_xa,
  output logic [TW-1:0]                o_xb,
  output logic [TW-1:0]                o_ya,
  output logic [TW-1:0]                o_yb
);
  import tlq_pkg::*;

  logic v_r, adv;
  logic [TW-1:0] s_ext, xa_try, xb_try, ya_try, yb_try, x_lhs, y_lhs;
  logic x_ok, y_ok;
  logic [MAG_BITS-1:0] bit_m;
  logic [4*COORD_BITS-1:0] pt_r;
  logic dxp_r, dyn_r;
  logic [2*AB:0] s_r;
  logic [2*NB-1:0] nx2_r, ny2_r;
  logic [MAG_BITS-1:0] cx_r, cy_r;
  logic [TW-1:0] xa_r, xb_r, ya_r, yb_r;

  assign adv   = !v_r || o_rdy;
  assign i_rdy = adv;
  assign bit_m = MAG_BITS'(1) << BIT;
  assign s_ext = TW'(i_s);

  // a = c*c*s, b = c*s; (2m-1)^2 s = 4a - 4b + s for m = c + 2^BIT
  assign xa_try = i_xa + (i_xb << (BIT + 1)) + (s_ext << (2*BIT));
  assign xb_try = i_xb + (s_ext << BIT);
  assign ya_try = i_ya + (i_yb << (BIT + 1)) + (s_ext << (2*BIT));
  assign yb_try = i_yb + (s_ext << BIT);
  assign x_lhs  = (xa_try << 2) + s_ext - (xb_try << 2);
  assign y_lhs  = (ya_try << 2) + s_ext - (yb_try << 2);
  assign x_ok   = x_lhs <= TW'(i_nx2);
  assign y_ok   = y_lhs <= TW'(i_ny2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && i_valid) begin
      pt_r  <= i_pt;
      dxp_r <= i_dx_pos;
      dyn_r <= i_dy_neg;
      s_r   <= i_s;
      nx2_r <= i_nx2;
      ny2_r <= i_ny2;
      cx_r  <= x_ok ? (i_cx | bit_m) : i_cx;
      xa_r  <= x_ok ? xa_try : i_xa;
      xb_r  <= x_ok ? xb_try : i_xb;
      cy_r  <= y_ok ? (i_cy | bit_m) : i_cy;
      ya_r  <= y_ok ? ya_try : i_ya;
      yb_r  <= y_ok ? yb_try : i_yb;
    end
  end

  assign o_valid  = v_r;
  assign o_pt     = pt_r;
  assign o_dx_pos = dxp_r;
  assign o_dy_neg = dyn_r;
  assign o_s      = s_r;
  assign o_nx2    = nx2_r;
  assign o_ny2    = ny2_r;
  assign o_cx     = cx_r;
  assign o_cy     = cy_r;
  assign o_xa     = xa_r;
  assign o_xb     = xb_r;
  assign o_ya     = ya_r;
  assign o_yb     = yb_r;
endmodule

// File: design/tlq_out.sv
// corner stage: signed offsets, corner sums with saturation, output register
`timescale 1ns / 1ps
module tlq_out #(
  parameter int COORD_BITS = tlq_pkg::COORD_BITS_DEF,
  localparam int AB = COORD_BITS + 1,
  localparam int EW = COORD_BITS + 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         i_valid,
  output logic                         i_rdy,
  input  logic [4*COORD_BITS-1:0]      i_pt,
  input  logic                         i_dx_pos,
  input  logic                         i_dy_neg,
  input  logic [2*AB:0]                i_s,
  input  logic [tlq_pkg::MAG_BITS-1:0] i_cx,
  input  logic [tlq_pkg::MAG_BITS-1:0] i_cy,
  output logic                         o_valid,
  input  logic                         o_stall,
  output logic [8*COORD_BITS-1:0]      o_corners
);
  import tlq_pkg::*;

  localparam logic [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

  function automatic logic [COORD_BITS-1:0] sat(input logic [EW-1:0] v);
    logic [2:0] top;
    top = v[EW-1:EW-3];
    if (!v[EW-1] && top != 3'b000) return MAXV;
    if (v[EW-1] && top != 3'b111) return MINV;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic logic [EW-1:0] sx2(input logic [COORD_BITS-1:0] c);
    return {{2{c[COORD_BITS-1]}}, c};
  endfunction

  logic v_r, adv;
  logic [MAG_BITS-1:0] mx, my;
  logic [EW-1:0] mx_e, my_e, ox, oy;
  logic [COORD_BITS-1:0] sx, sy, ex, ey;
  logic [8*COORD_BITS-1:0] corners_nxt, corners_r;

  assign adv   = !v_r || !o_stall;
  assign i_rdy = adv;

  // zero-length segment gives a zero offset
  assign mx   = (i_s == '0) ? '0 : i_cx;
  assign my   = (i_s == '0) ? '0 : i_cy;
  assign mx_e = EW'(mx);
  assign my_e = EW'(my);
  assign ox   = i_dy_neg ? (~mx_e + 1'b1) : mx_e;
  assign oy   = i_dx_pos ? (~my_e + 1'b1) : my_e;
  assign {sx, sy, ex, ey} = i_pt;

  assign corners_nxt = {sat(sx2(sx) + ox), sat(sx2(sy) + oy),
                        sat(sx2(sx) - ox), sat(sx2(sy) - oy),
                        sat(sx2(ex) + ox), sat(sx2(ey) + oy),
                        sat(sx2(ex) - ox), sat(sx2(ey) - oy)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && i_valid) begin
      corners_r <= corners_nxt;
    end
  end

  assign o_valid   = v_r;
  assign o_corners = corners_r;
endmodule

// File: design/thick_line_quad_vertices_core.sv
// top level of the thick-line quad expansion: register port and pipeline
// from input acceptance to out_valid: 3 front stages, 12 cells, 1 output stage
// one segment per cycle unless stalled; the 12 cells each settle one offset bit
// every stage has its own valid and advances when the stage behind it moves,
// so bubbles collapse and input is stalled only while the output is stalled
// reset (rst_n low, synchronous) empties the pipeline and sets line_width to 16
`timescale 1ns / 1ps
`include "thick_line_quad_vertices_core_defines.svh"
module thick_line_quad_vertices_core #(
  parameter int COORD_BITS = tlq_pkg::COORD_BITS_DEF,
  localparam int AB = COORD_BITS + 1,
  localparam int NB = AB + tlq_pkg::WIDTH_BITS,
  localparam int TW = 2*AB + 2*tlq_pkg::MAG_BITS + 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // segment input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  in_start_x,
  input  logic signed [COORD_BITS-1:0]  in_start_y,
  input  logic signed [COORD_BITS-1:0]  in_end_x,
  input  logic signed [COORD_BITS-1:0]  in_end_y,
  // quad corners
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  out_corner0_x,
  output logic signed [COORD_BITS-1:0]  out_corner0_y,
  output logic signed [COORD_BITS-1:0]  out_corner1_x,
  output logic signed [COORD_BITS-1:0]  out_corner1_y,
  output logic signed [COORD_BITS-1:0]  out_corner2_x,
  output logic signed [COORD_BITS-1:0]  out_corner2_y,
  output logic signed [COORD_BITS-1:0]  out_corner3_x,
  output logic signed [COORD_BITS-1:0]  out_corner3_y,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlq_pkg::ADDR_BITS-1:0] paddr,
  input  logic [tlq_pkg::DATA_BITS-1:0] pwdata,
  output logic [tlq_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);
  import tlq_pkg::*;

  localparam int MB = MAG_BITS;

  // line width register, word index taken from the upper address bit
  logic [WIDTH_BITS-1:0] line_width_r;
  logic reg_sel, reg_wr;

  assign reg_sel = paddr[ADDR_BITS-1] == REG_LINE_WIDTH;
  assign reg_wr  = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? DATA_BITS'(line_width_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= WIDTH_RESET;
    end else if (reg_wr) begin
      line_width_r <= pwdata[WIDTH_BITS-1:0];
    end
  end

  // chain links: index 0 is the front stage output, index MB the last cell
  logic                   v_w    [MB+1];
  logic                   rdy_w  [MB+1];
  logic [4*COORD_BITS-1:0] pt_w  [MB+1];
  logic                   dxp_w  [MB+1];
  logic                   dyn_w  [MB+1];
  logic [2*AB:0]          s_w    [MB+1];
  logic [2*NB-1:0]        nx2_w  [MB+1];
  logic [2*NB-1:0]        ny2_w  [MB+1];
  logic [MB-1:0]          cx_w   [MB+1];
  logic [MB-1:0]          cy_w   [MB+1];
  logic [TW-1:0]          xa_w   [MB+1];
  logic [TW-1:0]          xb_w   [MB+1];
  logic [TW-1:0]          ya_w   [MB+1];
  logic [TW-1:0]          yb_w   [MB+1];
  logic                   prep_rdy;
  logic [8*COORD_BITS-1:0] corners;

  assign in_stall = !prep_rdy;

  // differences, magnitudes, s = dx^2 + dy^2 and squared numerators
  tlq_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .i_valid  (in_valid),
    .i_rdy    (prep_rdy),
    .i_sx     (in_start_x),
    .i_sy     (in_start_y),
    .i_ex     (in_end_x),
    .i_ey     (in_end_y),
    .i_width  (line_width_r),
    .o_valid  (v_w[0]),
    .o_rdy    (rdy_w[0]),
    .o_pt     (pt_w[0]),
    .o_dx_pos (dxp_w[0]),
    .o_dy_neg (dyn_w[0]),
    .o_s      (s_w[0]),
    .o_nx2    (nx2_w[0]),
    .o_ny2    (ny2_w[0])
  );

  // search starts from a zero magnitude with zero running products
  assign cx_w[0] = '0;
  assign cy_w[0] = '0;
  assign xa_w[0] = '0;
  assign xb_w[0] = '0;
  assign ya_w[0] = '0;
  assign yb_w[0] = '0;

  // one cell per magnitude bit, most significant bit first
  for (genvar g = 0; g < MB; g++) begin : g_cell
    tlq_cell #(.COORD_BITS(COORD_BITS), .BIT(MB - 1 - g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .i_valid  (v_w[g]),
      .i_rdy    (rdy_w[g]),
      .i_pt     (pt_w[g]),
      .i_dx_pos (dxp_w[g]),
      .i_dy_neg (dyn_w[g]),
      .i_s      (s_w[g]),
      .i_nx2    (nx2_w[g]),
      .i_ny2    (ny2_w[g]),
      .i_cx     (cx_w[g]),
      .i_cy     (cy_w[g]),
      .i_xa     (xa_w[g]),
      .i_xb     (xb_w[g]),
      .i_ya     (ya_w[g]),
      .i_yb     (yb_w[g]),
      .o_valid  (v_w[g+1]),
      .o_rdy    (rdy_w[g+1]),
      .o_pt     (pt_w[g+1]),
      .o_dx_pos (dxp_w[g+1]),
      .o_dy_neg (dyn_w[g+1]),
      .o_s      (s_w[g+1]),
      .o_nx2    (nx2_w[g+1]),
      .o_ny2    (ny2_w[g+1]),
      .o_cx     (cx_w[g+1]),
      .o_cy     (cy_w[g+1]),
      .o_xa     (xa_w[g+1]),
      .o_xb     (xb_w[g+1]),
      .o_ya     (ya_w[g+1]),
      .o_yb     (yb_w[g+1])
    );
  end

  // signed offsets, four corners, saturation and the output register
  tlq_out #(.COORD_BITS(COORD_BITS)) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .i_valid   (v_w[MB]),
    .i_rdy     (rdy_w[MB]),
    .i_pt      (pt_w[MB]),
    .i_dx_pos  (dxp_w[MB]),
    .i_dy_neg  (dyn_w[MB]),
    .i_s       (s_w[MB]),
    .i_cx      (cx_w[MB]),
    .i_cy      (cy_w[MB]),
    .o_valid   (out_valid),
    .o_stall   (out_stall),
    .o_corners (corners)
  );

  assign {out_corner0_x, out_corner0_y, out_corner1_x, out_corner1_y,
          out_corner2_x, out_corner2_y, out_corner3_x, out_corner3_y} = corners;

  // input backs up only when a finished item is held at the output
  `TLQ_ASSERT_IMP(a_stall_only_when_full, in_stall, out_valid && out_stall)
  // an item leaving the last cell shows up at the output next cycle
  `TLQ_ASSERT_NXT(a_chain_to_out, v_w[MB] && rdy_w[MB], out_valid)
  // a register write lands in the width register
  `TLQ_ASSERT_NXT(a_cfg_write, reg_wr, line_width_r == $past(pwdata[WIDTH_BITS-1:0]))
endmodule

// File: test/thick_line_quad_vertices_core_tb.sv
// testbench for the thick-line quad expansion core: directed and random segments against a bit-true predictor
`timescale 1ns / 1ps
module thick_line_quad_vertices_core_tb;
  import tlq_pkg::*;

  localparam int CB = 20;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [CB-1:0] c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;
  } quad_t;

  // scoreboard: predicts the quad for each accepted segment and checks the corners
  class quad_scoreboard;
    quad_t pending[$];
    logic [WIDTH_BITS-1:0] width_q;
    int mismatches;

    function new();
      width_q = WIDTH_RESET;
      mismatches = 0;
    endfunction

    // nearest integer to num*w/(2*len), found by bisection on squared terms
    function automatic longint unsigned half_width_mag(longint unsigned num,
        longint unsigned ax, longint unsigned ay, longint unsigned w);
      longint unsigned lo, hi, mid, k;
      logic [127:0] rhs, lhs;
      lo = 0;
      hi = 4095;
      if (ax == 0 && ay == 0) return 0;
      rhs = 128'(num * w) * 128'(num * w);
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        k = 2 * mid - 1;
        lhs = 128'(k * ax) * 128'(k * ax) + 128'(k * ay) * 128'(k * ay);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function automatic logic signed [CB-1:0] clamp(longint v);
      longint maxv;
      maxv = (longint'(1) <<< (CB - 1)) - 1;
      if (v > maxv) v = maxv;
      if (v < -maxv - 1) v = -maxv - 1;
      return v[CB-1:0];
    endfunction

    function void note_segment(logic signed [CB-1:0] sx, sy, ex, ey);
      longint dx, dy, ox, oy;
      longint unsigned ax, ay;
      quad_t q;
      dx = longint'(ex) - longint'(sx);
      dy = longint'(ey) - longint'(sy);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      ox = half_width_mag(ay, ax, ay, width_q);
      oy = half_width_mag(ax, ax, ay, width_q);
      if (dy < 0) ox = -ox;
      if (dx > 0) oy = -oy;
      q.c0x = clamp(sx + ox); q.c0y = clamp(sy + oy);
      q.c1x = clamp(sx - ox); q.c1y = clamp(sy - oy);
      q.c2x = clamp(ex + ox); q.c2y = clamp(ey + oy);
      q.c3x = clamp(ex - ox); q.c3y = clamp(ey - oy);
      pending.push_back(q);
    endfunction

    function void check_quad(quad_t got);
      quad_t exp_q;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected quad %h", got);
        return;
      end
      exp_q = pending.pop_front();
      if (got !== exp_q) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("quad mismatch: expected %0d %0d %0d %0d %0d %0d %0d %0d",
            exp_q.c0x, exp_q.c0y, exp_q.c1x, exp_q.c1y,
            exp_q.c2x, exp_q.c2y, exp_q.c3x, exp_q.c3y);
          $display("               actual   %0d %0d %0d %0d %0d %0d %0d %0d",
            got.c0x, got.c0y, got.c1x, got.c1y, got.c2x, got.c2y, got.c3x, got.c3y);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [CB-1:0] in_start_x = 0, in_start_y = 0, in_end_x = 0, in_end_y = 0;
  logic out_valid;
  logic out_stall = 0;
  quad_t out_q;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_BITS-1:0] paddr = 0;
  logic [DATA_BITS-1:0] pwdata = 0;
  logic [DATA_BITS-1:0] prdata;
  logic pready;

  // idle percentages for sender and receiver
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int watchdog = 0;
  quad_scoreboard quad_sb;

  always #1 clk = ~clk;

  thick_line_quad_vertices_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_corner0_x(out_q.c0x), .out_corner0_y(out_q.c0y),
    .out_corner1_x(out_q.c1x), .out_corner1_y(out_q.c1y),
    .out_corner2_x(out_q.c2x), .out_corner2_y(out_q.c2y),
    .out_corner3_x(out_q.c3x), .out_corner3_y(out_q.c3y),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // result side: random stall, check every accepted quad
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) quad_sb.check_quad(out_q);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog: cycles without any accepted item
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) watchdog <= 0;
    else watchdog <= watchdog + 1;
  end

  // register write: setup then access cycle
  task automatic write_line_width(logic [WIDTH_BITS-1:0] w);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= ADDR_BITS'(32'(REG_LINE_WIDTH) * 4); pwdata <= DATA_BITS'(w);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    quad_sb.width_q = w;
  endtask

  // present one segment, with a random leading gap, hold it until accepted
  task automatic send_segment(logic signed [CB-1:0] sx, sy, ex, ey);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_start_x <= sx; in_start_y <= sy; in_end_x <= ex; in_end_y <= ey;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    quad_sb.note_segment(sx, sy, ex, ey);
  endtask

  // wait for the pipeline to drain before touching the register
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (quad_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [CB-1:0] rand_coord();
    case ($urandom_range(3))
      0: return CB'($urandom);
      1: return CB'($signed($urandom_range(4000)) - 2000);
      2: return $urandom_range(1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
      default: return CB'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  task automatic random_phase(int count);
    logic signed [CB-1:0] sx, sy;
    repeat (count) begin
      sx = rand_coord();
      sy = rand_coord();
      case ($urandom_range(4))
        // nearby endpoint, the common case for short strokes
        0, 1: send_segment(sx, sy, sx + CB'($signed($urandom_range(512)) - 256),
                           sy + CB'($signed($urandom_range(512)) - 256));
        // axis aligned, degenerate or with both ends random
        2: send_segment(sx, sy, $urandom_range(1) ? sx : rand_coord(),
                        $urandom_range(1) ? sy : rand_coord());
        default: send_segment(sx, sy, rand_coord(), rand_coord());
      endcase
    end
  endtask

  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  initial begin
    quad_sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset width, zero length, axes, diagonals, extremes, saturation, then maximum and zero width
    send_segment(0, 0, 0, 0);
    send_segment(100, 200, 100, 200);
    send_segment(0, 0, 160, 0);
    send_segment(0, 0, 0, -160);
    send_segment(0, 0, -160, 0);
    send_segment(0, 0, 0, 160);
    send_segment(10, 10, 26, 26);
    send_segment(-5, 7, -21, -9);
    send_segment(CMIN, CMIN, CMAX, CMAX);
    send_segment(CMAX, CMIN, CMIN, CMAX);
    send_segment(CMAX, CMAX, CMAX, CMIN);
    send_segment(CMIN, 0, CMAX, 0);
    send_segment(CMAX, CMAX, CMAX - 1, CMAX);
    send_segment(-1, -1, 0, 0);
    drain();
    write_line_width(12'hFFF);
    send_segment(CMAX, CMAX, CMAX, CMIN);
    send_segment(CMIN, CMIN, CMIN, CMAX);
    send_segment(0, 0, 3, 1);
    send_segment(0, 0, 1, 0);
    send_segment(0, 0, 0, 0);
    drain();
    write_line_width(0);
    send_segment(0, 0, 50, 70);
    send_segment(CMIN, CMAX, CMAX, CMIN);
    drain();

    // random phases over widths and idle patterns
    write_line_width(WIDTH_RESET);
    send_idle_pct = 21; recv_idle_pct = 64;
    random_phase(400);
    drain();
    write_line_width(WIDTH_BITS'($urandom));
    send_idle_pct = 64; recv_idle_pct = 21;
    random_phase(400);
    drain();
    write_line_width(12'hFFF);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(350);
    drain();
    write_line_width(WIDTH_BITS'($urandom_range(64, 1)));
    random_phase(350);

    in_valid <= 0;
    while (quad_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (quad_sb.mismatches == 0 && quad_sb.pending.size() == 0)
      $display("thick_line_quad_vertices_core test passed");
    else
      $display("thick_line_quad_vertices_core test failed");
    $finish;
  end

  // timeout
  initial begin
    wait (watchdog >= WATCHDOG_LIMIT);
    $display("thick_line_quad_vertices_core test failed");
    $finish;
  end
endmodule

// File: files.f
+incdir+design
design/tlq_pkg.sv
design/tlq_prep.sv
design/tlq_cell.sv
design/tlq_out.sv
design/thick_line_quad_vertices_core.sv
test/thick_line_quad_vertices_core_tb.sv
